/* hdl/atpg_pkg.sv */
// ----------------------------------------------------------------------------
// atpg_pkg
// Shared widths, codes, constants and the job type of the test pattern block.
// ----------------------------------------------------------------------------
package atpg_pkg;

  localparam int COORD_BITS = 12;                  // raster coordinate width
  localparam int PAD_BITS   = COORD_BITS - 1;      // border width register
  localparam int GEO_BITS   = COORD_BITS + 2;      // signed geometry values
  localparam int SQ_BITS    = 2 * GEO_BITS;        // squared distances
  localparam int R2_BITS    = SQ_BITS + 1;         // sum of two squares
  localparam int KEY_BITS   = 10;
  localparam int TIME_BITS  = 32;
  localparam int COLOR_BITS = 24;
  localparam int ALPHA_BITS = 8;

  localparam int QDEPTH     = 4;
  localparam int QAW        = $clog2(QDEPTH);

  // configuration register indexes
  localparam logic [1:0] REG_FRAME_WIDTH    = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_BORDER_PADDING = 2'd2;

  localparam logic [COORD_BITS-1:0] RST_FRAME_WIDTH    = COORD_BITS'(500);
  localparam logic [COORD_BITS-1:0] RST_FRAME_HEIGHT   = COORD_BITS'(550);
  localparam logic [PAD_BITS-1:0]   RST_BORDER_PADDING = PAD_BITS'(20);

  // input actions and key codes
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_KEY   = 1'b1;
  localparam logic [KEY_BITS-1:0] KEY_UP   = KEY_BITS'('h67);
  localparam logic [KEY_BITS-1:0] KEY_DOWN = KEY_BITS'('h6C);

  localparam logic [TIME_BITS-1:0] RST_SPEED = TIME_BITS'(16);

  // shading constants
  localparam logic signed [GEO_BITS-1:0] RING_INSET = GEO_BITS'(8);
  localparam logic signed [GEO_BITS-1:0] RING_WIDTH = GEO_BITS'(32);
  localparam logic signed [GEO_BITS-1:0] LINE_HALF  = GEO_BITS'(6);
  localparam int SHIFT_INNER_R2 = 5;
  localparam int SHIFT_INNER_T  = 6;
  localparam int SHIFT_RING_T   = 5;
  localparam int SHIFT_OUTER_T  = 4;
  localparam logic [COLOR_BITS-1:0] COLOR_STEP   = COLOR_BITS'('h0080401);
  localparam logic [ALPHA_BITS-1:0] ALPHA_OPAQUE = 8'hff;
  localparam logic [ALPHA_BITS-1:0] ALPHA_CLEAR  = 8'h00;

  // one pixel to shade: position, frame time and end-of-frame flag
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [TIME_BITS-1:0]  t;
    logic                  last;
  } job_t;

endpackage

/* hdl/atpg_front.sv */
// ----------------------------------------------------------------------------
// atpg_front
// Accepts beats, applies key events and walks the raster; queues pixel jobs.
// ----------------------------------------------------------------------------
module atpg_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_action,
  input  logic [atpg_pkg::KEY_BITS-1:0]  in_key_code,
  input  logic [atpg_pkg::COORD_BITS-1:0] frame_width,
  input  logic [atpg_pkg::COORD_BITS-1:0] frame_height,
  input  logic [atpg_pkg::PAD_BITS-1:0]   border_padding,
  input  logic                           q_full,
  output logic                           q_push,
  output atpg_pkg::job_t                 q_job
);
  import atpg_pkg::*;

  logic [COORD_BITS-1:0] col_r, col_nxt;
  logic [COORD_BITS-1:0] row_r, row_nxt;
  logic                  in_frame_r, in_frame_nxt;
  logic [TIME_BITS-1:0]  ftime_r, ftime_nxt;
  logic [TIME_BITS-1:0]  speed_r, speed_nxt;

  logic                  accept;
  logic [COORD_BITS-1:0] pad_c;
  logic                  cur_ok;
  logic                  start_ok;
  logic [COORD_BITS-1:0] x_sel;
  logic [COORD_BITS-1:0] y_sel;
  logic [TIME_BITS-1:0]  t_sel;
  logic                  col_end;
  logic                  row_end;

  // c in [p, W-p) and r in [p, H-p), without signed math
  function automatic logic pos_active(input logic [COORD_BITS-1:0] c,
                                      input logic [COORD_BITS-1:0] r,
                                      input logic [COORD_BITS-1:0] w,
                                      input logic [COORD_BITS-1:0] h,
                                      input logic [PAD_BITS-1:0]   p);
    logic [COORD_BITS:0] c_lim;
    logic [COORD_BITS:0] r_lim;
    c_lim = {1'b0, c} + {2'b00, p};
    r_lim = {1'b0, r} + {2'b00, p};
    return ({1'b0, c} >= {2'b00, p}) && (c_lim < {1'b0, w}) &&
           ({1'b0, r} >= {2'b00, p}) && (r_lim < {1'b0, h});
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign pad_c    = {1'b0, border_padding};

  always_comb begin
    cur_ok   = in_frame_r && pos_active(col_r, row_r, frame_width, frame_height,
                                        border_padding);
    start_ok = pos_active(pad_c, pad_c, frame_width, frame_height, border_padding);
    x_sel    = cur_ok ? col_r : pad_c;
    y_sel    = cur_ok ? row_r : pad_c;
    t_sel    = cur_ok ? ftime_r : ftime_r + speed_r;
    col_end  = ({1'b0, x_sel} + (COORD_BITS+1)'(1) + {2'b00, border_padding})
               >= {1'b0, frame_width};
    row_end  = ({1'b0, y_sel} + (COORD_BITS+1)'(1) + {2'b00, border_padding})
               >= {1'b0, frame_height};

    col_nxt      = col_r;
    row_nxt      = row_r;
    in_frame_nxt = in_frame_r;
    ftime_nxt    = ftime_r;
    speed_nxt    = speed_r;
    q_push       = 1'b0;
    q_job.x      = x_sel;
    q_job.y      = y_sel;
    q_job.t      = t_sel;
    q_job.last   = col_end && row_end;

    if (accept) begin
      if (in_action == ACT_KEY) begin
        if (in_key_code == KEY_UP) begin
          speed_nxt = speed_r + TIME_BITS'(1);
        end else if (in_key_code == KEY_DOWN) begin
          speed_nxt = speed_r - TIME_BITS'(1);
        end
      end else begin
        ftime_nxt = t_sel;
        if (!cur_ok && !start_ok) begin
          // empty active area: frame time moves, nothing is drawn
          col_nxt      = pad_c;
          row_nxt      = pad_c;
          in_frame_nxt = 1'b0;
        end else begin
          q_push = 1'b1;
          if (col_end) begin
            col_nxt = pad_c;
            if (row_end) begin
              row_nxt      = pad_c;
              in_frame_nxt = 1'b0;
            end else begin
              row_nxt      = y_sel + COORD_BITS'(1);
              in_frame_nxt = 1'b1;
            end
          end else begin
            col_nxt      = x_sel + COORD_BITS'(1);
            row_nxt      = y_sel;
            in_frame_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      in_frame_r <= 1'b0;
      ftime_r    <= '0;
      speed_r    <= RST_SPEED;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      in_frame_r <= in_frame_nxt;
      ftime_r    <= ftime_nxt;
      speed_r    <= speed_nxt;
    end
  end

endmodule

/* hdl/atpg_queue.sv */
// ----------------------------------------------------------------------------
// atpg_queue
// Small register FIFO of pixel jobs between the raster front and the shader.
// ----------------------------------------------------------------------------
module atpg_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  atpg_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output atpg_pkg::job_t head_job
);
  import atpg_pkg::*;

  job_t             mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r;
  logic [QAW-1:0]   rd_ptr_r;
  logic [QAW:0]     cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full     = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + (QAW+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - (QAW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* hdl/atpg_shade.sv */
// ----------------------------------------------------------------------------
// atpg_shade
// Four-stage shading pipeline: distance, squares, band select, color multiply.
// ----------------------------------------------------------------------------
module atpg_shade (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [atpg_pkg::COORD_BITS-1:0] frame_width,
  input  logic [atpg_pkg::COORD_BITS-1:0] frame_height,
  input  logic [atpg_pkg::PAD_BITS-1:0]   border_padding,
  input  logic                            q_empty,
  input  atpg_pkg::job_t                  q_head,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [31:0]                     out_pixel_value,
  output logic [atpg_pkg::COORD_BITS-1:0] out_pixel_x,
  output logic [atpg_pkg::COORD_BITS-1:0] out_pixel_y,
  output logic                            out_frame_end
);
  import atpg_pkg::*;

  // geometry, rebuilt from the config registers every cycle
  logic signed [GEO_BITS-1:0] dw_c, dh_c, halfw_c, halfh_c, hw_c, hh_c;
  logic signed [GEO_BITS-1:0] mn_c, o_c, i_c;
  logic signed [GEO_BITS-1:0] hw_r, hh_r, o_r, i_r;
  logic signed [SQ_BITS-1:0]  osq_s, isq_s;
  logic [SQ_BITS-1:0]         osq_r, isq_r;

  logic adv;

  // stage A
  logic signed [GEO_BITS-1:0] dx_c, dy_c, dxy_c, dsum_c;
  logic                       on_line_c;
  logic                       a_v_r;
  logic signed [GEO_BITS-1:0] a_dx_r, a_dy_r;
  logic [COORD_BITS-1:0]      a_x_r, a_y_r;
  logic                       a_last_r, a_line_r;
  logic [TIME_BITS-1:0]       a_ring_r, a_outer_r, a_tin_r;

  // stage B
  logic signed [SQ_BITS-1:0]  sqx_s, sqy_s;
  logic                       b_v_r;
  logic [SQ_BITS-1:0]         b_sqx_r, b_sqy_r;
  logic [COORD_BITS-1:0]      b_x_r, b_y_r;
  logic                       b_last_r, b_line_r;
  logic [TIME_BITS-1:0]       b_ring_r, b_outer_r, b_tin_r;

  // stage C
  logic [R2_BITS-1:0]         r2_c;
  logic [TIME_BITS-1:0]       base_c;
  logic                       c_v_r;
  logic [COLOR_BITS-1:0]      c_base_r;
  logic [COORD_BITS-1:0]      c_x_r, c_y_r;
  logic                       c_last_r, c_line_r;

  logic                       out_valid_r;

  // ---- geometry (C-style truncating halves) ----
  always_comb begin
    dw_c    = $signed({2'b00, frame_width}) - $signed({2'b00, border_padding, 1'b0});
    dh_c    = $signed({2'b00, frame_height}) - $signed({2'b00, border_padding, 1'b0});
    halfw_c = (dw_c + $signed(GEO_BITS'(dw_c[GEO_BITS-1]))) >>> 1;
    halfh_c = (dh_c + $signed(GEO_BITS'(dh_c[GEO_BITS-1]))) >>> 1;
    hw_c    = $signed({3'b000, border_padding}) + halfw_c;
    hh_c    = $signed({3'b000, border_padding}) + halfh_c;
    mn_c    = (hw_c < hh_c) ? hw_c : hh_c;
    o_c     = mn_c - RING_INSET;
    i_c     = o_c - RING_WIDTH;
  end

  assign osq_s = o_r * o_r;
  assign isq_s = i_r * i_r;

  always_ff @(posedge clk) begin
    hw_r  <= hw_c;
    hh_r  <= hh_c;
    o_r   <= o_c;
    i_r   <= i_c;
    osq_r <= $unsigned(osq_s);
    isq_r <= $unsigned(isq_s);
  end

  // ---- pipeline advance ----
  assign adv   = !out_valid_r || out_ready;
  assign q_pop = adv && !q_empty;

  always_comb begin
    dx_c   = $signed({2'b00, q_head.x}) - hw_r;
    dy_c   = $signed({2'b00, q_head.y}) - hh_r;
    dxy_c  = $signed({2'b00, q_head.x}) - $signed({2'b00, q_head.y});
    dsum_c = $signed({2'b00, q_head.x}) + $signed({2'b00, q_head.y})
             - $signed({2'b00, frame_height});
    on_line_c = (dxy_c <= LINE_HALF && dxy_c >= -LINE_HALF) ||
                (dsum_c <= LINE_HALF && dsum_c >= -LINE_HALF);
  end

  assign sqx_s = a_dx_r * a_dx_r;
  assign sqy_s = a_dy_r * a_dy_r;

  always_comb begin
    r2_c = {1'b0, b_sqx_r} + {1'b0, b_sqy_r};
    if (r2_c < {1'b0, isq_r}) begin
      base_c = TIME_BITS'(r2_c >> SHIFT_INNER_R2) + b_tin_r;
    end else if (r2_c < {1'b0, osq_r}) begin
      base_c = b_ring_r;
    end else begin
      base_c = b_outer_r;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      c_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      a_v_r       <= !q_empty;
      b_v_r       <= a_v_r;
      c_v_r       <= b_v_r;
      out_valid_r <= c_v_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      a_dx_r    <= dx_c;
      a_dy_r    <= dy_c;
      a_x_r     <= q_head.x;
      a_y_r     <= q_head.y;
      a_last_r  <= q_head.last;
      a_line_r  <= on_line_c;
      a_ring_r  <= TIME_BITS'(q_head.y) + (q_head.t >> SHIFT_RING_T);
      a_outer_r <= TIME_BITS'(q_head.x) + (q_head.t >> SHIFT_OUTER_T);
      a_tin_r   <= q_head.t >> SHIFT_INNER_T;

      b_sqx_r   <= $unsigned(sqx_s);
      b_sqy_r   <= $unsigned(sqy_s);
      b_x_r     <= a_x_r;
      b_y_r     <= a_y_r;
      b_last_r  <= a_last_r;
      b_line_r  <= a_line_r;
      b_ring_r  <= a_ring_r;
      b_outer_r <= a_outer_r;
      b_tin_r   <= a_tin_r;

      c_base_r  <= base_c[COLOR_BITS-1:0];
      c_x_r     <= b_x_r;
      c_y_r     <= b_y_r;
      c_last_r  <= b_last_r;
      c_line_r  <= b_line_r;

      out_pixel_value <= {(c_line_r ? ALPHA_CLEAR : ALPHA_OPAQUE),
                          COLOR_BITS'(c_base_r * COLOR_STEP)};
      out_pixel_x     <= c_x_r;
      out_pixel_y     <= c_y_r;
      out_frame_end   <= c_last_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* hdl/animated_test_pattern_generator.sv */
// ----------------------------------------------------------------------------
// animated_test_pattern_generator
// Animated ring test pattern: one ARGB pixel per next-pixel beat.
// ----------------------------------------------------------------------------
// Each next-pixel beat on the in_ channel yields one out_ beat with the pixel
// at the current raster position of the active area (frame minus border),
// row by row; key beats (up 0x67 / down 0x6C) change the animation speed and
// yield nothing, as do pixel beats while the active area is empty. The block
// takes one beat per clock and delivers one pixel per clock while out_ready
// holds and the queue has room: the front advances the raster position on each
// accepted pixel beat, a 4-entry job queue follows, and the shader is a 4-stage
// pipeline ending in the output register. in_ready drops only while
// the queue is full, i.e. after the sink has stalled out_ready for a while.
// Config writes (cfg_index 0 width, 1 height, 2 border) are taken every
// cycle and must only be issued while no pixel is in flight.
// ----------------------------------------------------------------------------
module animated_test_pattern_generator (
  input  logic                            clk,
  input  logic                            rst_n,
  // config write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [atpg_pkg::COORD_BITS-1:0] cfg_wdata,
  // input beats
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_action,
  input  logic [atpg_pkg::KEY_BITS-1:0]   in_key_code,
  // pixel beats
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [31:0]                     out_pixel_value,
  output logic [atpg_pkg::COORD_BITS-1:0] out_pixel_x,
  output logic [atpg_pkg::COORD_BITS-1:0] out_pixel_y,
  output logic                            out_frame_end
);
  import atpg_pkg::*;

  logic [COORD_BITS-1:0] frame_width_r;
  logic [COORD_BITS-1:0] frame_height_r;
  logic [PAD_BITS-1:0]   border_padding_r;

  logic q_push, q_full, q_pop, q_empty;
  job_t q_job, q_head;

  // config registers; the write port never stalls
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r    <= RST_FRAME_WIDTH;
      frame_height_r   <= RST_FRAME_HEIGHT;
      border_padding_r <= RST_BORDER_PADDING;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:    frame_width_r    <= cfg_wdata;
        REG_FRAME_HEIGHT:   frame_height_r   <= cfg_wdata;
        REG_BORDER_PADDING: border_padding_r <= cfg_wdata[PAD_BITS-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // raster walk, key handling, frame time
  atpg_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_key_code    (in_key_code),
    .frame_width    (frame_width_r),
    .frame_height   (frame_height_r),
    .border_padding (border_padding_r),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_job          (q_job)
  );

  // decouples the raster walk from output backpressure
  atpg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_job (q_head)
  );

  // shading pipeline; geometry regs, then their squares, are registered from the
  // config registers before any job can reach the stages that read them
  atpg_shade u_shade (
    .clk             (clk),
    .rst_n           (rst_n),
    .frame_width     (frame_width_r),
    .frame_height    (frame_height_r),
    .border_padding  (border_padding_r),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_value (out_pixel_value),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_frame_end   (out_frame_end)
  );

endmodule

/* hdl/atpg_checker.sv */
// ----------------------------------------------------------------------------
// atpg_checker
// Port-level checks for the test pattern block, bound to the top level.
// ----------------------------------------------------------------------------
module atpg_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [31:0]                     out_pixel_value,
  input logic [atpg_pkg::COORD_BITS-1:0] out_pixel_x,
  input logic [atpg_pkg::COORD_BITS-1:0] out_pixel_y,
  input logic                            out_frame_end
);
  import atpg_pkg::*;

  // reset empties the pipeline
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // stalled pixel beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_value) &&
    $stable(out_pixel_x) && $stable(out_pixel_y) && $stable(out_frame_end))
    else $error("stalled pixel beat changed");

  // alpha is either fully opaque or fully clear
  a_alpha_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pixel_value[31:24] == ALPHA_OPAQUE ||
                   out_pixel_value[31:24] == ALPHA_CLEAR))
    else $error("bad alpha byte");

  // the main diagonal is always on the clear cross line
  a_diag_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_pixel_x == out_pixel_y) |->
    out_pixel_value[31:24] == ALPHA_CLEAR)
    else $error("diagonal pixel not clear");

endmodule

bind animated_test_pattern_generator atpg_checker u_atpg_checker (.*);
